// File: design/rpc_pkg.sv
// Shared types, constants and CORDIC helpers for the rectangular/polar converter.
`default_nettype none
package rpc_pkg;

  // Number of CORDIC micro-rotations in the back end (12 to 32).
  localparam int unsigned CORDIC_STAGES = 24;
  localparam int unsigned QUEUE_DEPTH   = 4;

  localparam logic [1:0] FORM_RECT  = 2'd0;
  localparam logic [1:0] FORM_POLAR = 2'd1;

  localparam logic signed [35:0] DEG180_Q24 = 36'sd3019898880;
  localparam logic signed [35:0] DEG90_Q24  = 36'sd1509949440;
  localparam logic signed [25:0] DEG180_Q16 = 26'sd11796480;
  localparam logic signed [25:0] DEG360_Q16 = 26'sd23592960;
  localparam logic signed [30:0] INV_GAIN_Q30 = 31'sd652032874;
  localparam logic [31:0]        INV_GAIN_Q32 = 32'd2608131496;

  // One item as it travels from the front end through the queue and CORDIC stages.
  typedef struct packed {
    logic [1:0]         form;
    logic               zero;
    logic signed [31:0] a;
    logic signed [24:0] b;
    logic signed [51:0] x;
    logic signed [51:0] y;
    logic signed [35:0] z;
  } rpc_item_t;

  // atan(2^-i) in degrees, Q.24.
  function automatic logic signed [35:0] rpc_atan_q24(input int unsigned i);
    logic signed [35:0] r;
    case (i)
      0:  r = 36'sd754974720;
      1:  r = 36'sd445687602;
      2:  r = 36'sd235489088;
      3:  r = 36'sd119537938;
      4:  r = 36'sd60000934;
      5:  r = 36'sd30029717;
      6:  r = 36'sd15018523;
      7:  r = 36'sd7509720;
      8:  r = 36'sd3754917;
      9:  r = 36'sd1877466;
      10: r = 36'sd938734;
      11: r = 36'sd469367;
      12: r = 36'sd234684;
      13: r = 36'sd117342;
      14: r = 36'sd58671;
      15: r = 36'sd29335;
      16: r = 36'sd14668;
      17: r = 36'sd7334;
      18: r = 36'sd3667;
      19: r = 36'sd1833;
      20: r = 36'sd917;
      21: r = 36'sd458;
      22: r = 36'sd229;
      23: r = 36'sd115;
      24: r = 36'sd57;
      25: r = 36'sd29;
      26: r = 36'sd14;
      27: r = 36'sd7;
      28: r = 36'sd4;
      29: r = 36'sd2;
      30: r = 36'sd1;
      default: r = 36'sd0;
    endcase
    return r;
  endfunction

  // One micro-rotation; vectoring for the rectangular form, rotation otherwise.
  function automatic rpc_item_t rpc_micro_rot(input rpc_item_t it, input int unsigned sh);
    rpc_item_t          r;
    logic signed [51:0] xv;
    logic signed [51:0] yv;
    logic signed [51:0] xs;
    logic signed [51:0] ys;
    logic signed [35:0] zv;
    logic signed [35:0] at;
    logic               neg;
    r  = it;
    xv = it.x;
    yv = it.y;
    zv = it.z;
    xs = xv >>> sh;
    ys = yv >>> sh;
    at = rpc_atan_q24(sh);
    neg = (it.form == FORM_RECT) ? !yv[51] : zv[35];
    if (neg) begin
      r.x = xv + ys;
      r.y = yv - xs;
      r.z = zv + at;
    end else begin
      r.x = xv - ys;
      r.y = yv + xs;
      r.z = zv - at;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: design/rect_polar_converter.sv
// Top level of the CORDIC rectangular/polar converter.
`default_nettype none
// Converts a plane vector between rectangular form (x in Q15.16, y in Q8.16 on
// input and Q15.16 on output) and polar form (magnitude in Q15.16, angle in Q8.16
// degrees) with a pipelined CORDIC. A request of the rectangular form returns
// magnitude and atan2 angle with x and y echoed; a polar request returns saturated
// x and y with magnitude and angle echoed; any other form code returns all zeros
// with the invalid flag set. The block takes one request per cycle while the
// result side is not stalled and returns one result per request, in order. A
// request passes through the front-end stages, the queue, one CORDIC stage per
// micro-rotation (CORDIC_STAGES, 24), one gain-correction stage and the output
// register. The four-entry queue lets the front end keep accepting requests while
// the result side is stalled, until it is full. No clearing pass or warm-up after reset.
module rect_polar_converter import rpc_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [63:0]  in_tdata,   // [31:0] first_value, [56:32] second_value, zero pad
  input  wire logic [1:0]   in_tuser,   // [1:0] req_type
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [127:0]      out_tdata,  // [31:0] x_coord, [63:32] y_coord,
                                        // [96:64] magnitude, [121:97] angle_deg, zero pad
  output logic [1:0]        out_tuser   // [0] form_out, [1] invalid_form
);

  logic        fq_valid;
  logic        fq_ready;
  rpc_item_t   fq_item;
  logic        qb_valid;
  logic        qb_ready;
  rpc_item_t   qb_item;
  logic [31:0] x_coord;
  logic [31:0] y_coord;
  logic [32:0] magnitude;
  logic [24:0] angle_deg;
  logic        form_out;
  logic        invalid_form;

  rpc_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .req_type     (in_tuser),
    .first_value  (in_tdata[31:0]),
    .second_value (in_tdata[56:32]),
    .out_valid    (fq_valid),
    .out_ready    (fq_ready),
    .out_item     (fq_item)
  );

  rpc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fq_valid),
    .in_ready  (fq_ready),
    .in_item   (fq_item),
    .out_valid (qb_valid),
    .out_ready (qb_ready),
    .out_item  (qb_item)
  );

  // The back end pulls from the queue only when its pipeline advances.
  rpc_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (qb_valid),
    .in_ready     (qb_ready),
    .in_item      (qb_item),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .x_coord      (x_coord),
    .y_coord      (y_coord),
    .magnitude    (magnitude),
    .angle_deg    (angle_deg),
    .form_out     (form_out),
    .invalid_form (invalid_form)
  );

  assign out_tdata = {6'b0, angle_deg, magnitude, y_coord, x_coord};
  assign out_tuser = {invalid_form, form_out};

endmodule
`default_nettype wire

// File: design/rpc_front.sv
// Front end: takes requests, classifies the form and prepares the CORDIC start vector.
`default_nettype none
module rpc_front import rpc_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         req_type,
  input  wire logic signed [31:0] first_value,
  input  wire logic signed [24:0] second_value,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output rpc_item_t               out_item
);

  logic               s1_v_r;
  logic [1:0]         s1_form_r;
  logic               s1_zero_r;
  logic signed [31:0] s1_a_r;
  logic signed [24:0] s1_b_r;
  logic signed [32:0] s1_m_r;
  logic signed [25:0] s1_y_r;
  logic signed [35:0] s1_z_r;
  logic               s2_v_r;
  rpc_item_t          s2_item_r;

  logic               s1_ready;
  logic               s2_ready;
  logic signed [32:0] a_ext;
  logic signed [25:0] b_ext;
  logic signed [25:0] b_wrap;
  logic signed [35:0] z_pol;
  logic signed [32:0] m_nxt;
  logic signed [25:0] y_nxt;
  logic signed [35:0] z_nxt;
  logic signed [62:0] prod;
  logic signed [62:0] prod_sh;
  rpc_item_t          item_nxt;

  assign s2_ready = !s2_v_r || out_ready;
  assign s1_ready = !s1_v_r || s2_ready;
  assign in_ready = s1_ready;

  always_comb begin
    a_ext  = {first_value[31], first_value};
    b_ext  = {second_value[24], second_value};
    b_wrap = b_ext;
    if (b_ext > DEG180_Q16) begin
      b_wrap = b_ext - DEG360_Q16;
    end else if (b_ext < -DEG180_Q16) begin
      b_wrap = b_ext + DEG360_Q16;
    end
    z_pol = {{2{b_wrap[25]}}, b_wrap, 8'b0};
    m_nxt = a_ext;
    y_nxt = b_ext;
    z_nxt = '0;
    if (req_type == FORM_RECT) begin
      if (first_value[31]) begin
        m_nxt = -a_ext;
        y_nxt = -b_ext;
        z_nxt = second_value[24] ? -DEG180_Q24 : DEG180_Q24;
      end
    end else begin
      z_nxt = z_pol;
      if (z_pol > DEG90_Q24) begin
        m_nxt = -a_ext;
        z_nxt = z_pol - DEG180_Q24;
      end else if (z_pol < -DEG90_Q24) begin
        m_nxt = -a_ext;
        z_nxt = z_pol + DEG180_Q24;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_v_r <= in_valid;
      end
      if (s2_ready) begin
        s2_v_r <= s1_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      s1_form_r <= req_type;
      s1_zero_r <= (first_value == 32'sd0) && (second_value == 25'sd0);
      s1_a_r    <= first_value;
      s1_b_r    <= second_value;
      s1_m_r    <= m_nxt;
      s1_y_r    <= y_nxt;
      s1_z_r    <= z_nxt;
    end
  end

  // Polar form: pre-scale the magnitude by the inverse CORDIC gain.
  assign prod    = s1_m_r * INV_GAIN_Q30;
  assign prod_sh = prod >>> 14;

  always_comb begin
    item_nxt.form = s1_form_r;
    item_nxt.zero = s1_zero_r;
    item_nxt.a    = s1_a_r;
    item_nxt.b    = s1_b_r;
    item_nxt.z    = s1_z_r;
    if (s1_form_r == FORM_RECT) begin
      item_nxt.x = {{3{s1_m_r[32]}}, s1_m_r, 16'b0};
      item_nxt.y = {{10{s1_y_r[25]}}, s1_y_r, 16'b0};
    end else begin
      item_nxt.x = prod_sh[51:0];
      item_nxt.y = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_v_r) begin
      s2_item_r <= item_nxt;
    end
  end

  assign out_valid = s2_v_r;
  assign out_item  = s2_item_r;

endmodule
`default_nettype wire

// File: design/rpc_queue.sv
// Short queue between the front end and the CORDIC back end.
`default_nettype none
module rpc_queue import rpc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire rpc_item_t  in_item,
  output logic            out_valid,
  input  wire logic       out_ready,
  output rpc_item_t       out_item
);

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);

  rpc_item_t     mem_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [PW:0]   count_r;
  logic          push;
  logic          pop;

  assign in_ready  = (count_r != PW'(0) + (PW+1)'(QUEUE_DEPTH));
  assign out_valid = (count_r != '0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_item  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + (PW+1)'(1);
      end else if (pop && !push) begin
        count_r <= count_r - (PW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_item;
    end
  end

endmodule
`default_nettype wire

// File: design/rpc_back.sv
// Back end: pipelined CORDIC, gain correction, rounding and the output register.
`default_nettype none
module rpc_back import rpc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire rpc_item_t   in_item,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      x_coord,
  output logic [31:0]      y_coord,
  output logic [32:0]      magnitude,
  output logic [24:0]      angle_deg,
  output logic             form_out,
  output logic             invalid_form
);

  rpc_item_t                stg_r [CORDIC_STAGES];
  logic [CORDIC_STAGES-1:0] v_r;
  logic                     adv;

  logic               p_v_r;
  logic [1:0]         p_form_r;
  logic               p_zero_r;
  logic signed [31:0] p_a_r;
  logic signed [24:0] p_b_r;
  logic [63:0]        p_lo_r;
  logic [51:0]        p_hi_r;
  logic [31:0]        p_x_r;
  logic [31:0]        p_y_r;
  logic [24:0]        p_ang_r;

  logic               o_v_r;
  logic [31:0]        o_x_r;
  logic [31:0]        o_y_r;
  logic [32:0]        o_mag_r;
  logic [24:0]        o_ang_r;
  logic               o_form_r;
  logic               o_inv_r;

  rpc_item_t          last;
  logic signed [51:0] lx;
  logic signed [51:0] ly;
  logic signed [35:0] lz;
  logic signed [51:0] rx;
  logic signed [51:0] ry;
  logic signed [35:0] rz;
  logic [31:0]        sx;
  logic [31:0]        sy;
  logic [24:0]        sa;
  logic [52:0]        mprod;
  logic [52:0]        mround;

  // Whole back end moves together whenever the output register can take a result.
  assign adv      = !o_v_r || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r   <= '0;
      p_v_r <= 1'b0;
      o_v_r <= 1'b0;
    end else if (adv) begin
      v_r   <= {v_r[CORDIC_STAGES-2:0], in_valid};
      p_v_r <= v_r[CORDIC_STAGES-1];
      o_v_r <= p_v_r;
    end
  end

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_stage
    if (k == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (adv) begin
          stg_r[k] <= rpc_micro_rot(in_item, k);
        end
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (adv) begin
          stg_r[k] <= rpc_micro_rot(stg_r[k-1], k);
        end
      end
    end
  end

  always_comb begin
    last = stg_r[CORDIC_STAGES-1];
    lx   = last.x;
    ly   = last.y;
    lz   = last.z;
    rx   = (lx + 52'sd32768) >>> 16;
    ry   = (ly + 52'sd32768) >>> 16;
    rz   = (lz + 36'sd128) >>> 8;
    if (rx > 52'sd2147483647) begin
      sx = 32'h7fff_ffff;
    end else if (rx < -52'sd2147483648) begin
      sx = 32'h8000_0000;
    end else begin
      sx = rx[31:0];
    end
    if (ry > 52'sd2147483647) begin
      sy = 32'h7fff_ffff;
    end else if (ry < -52'sd2147483648) begin
      sy = 32'h8000_0000;
    end else begin
      sy = ry[31:0];
    end
    if (rz > 36'sd11796480) begin
      sa = 25'd11796480;
    end else if (rz < -36'sd11796480) begin
      sa = 25'h14c0000;
    end else begin
      sa = rz[24:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_form_r <= last.form;
      p_zero_r <= last.zero;
      p_a_r    <= last.a;
      p_b_r    <= last.b;
      p_lo_r   <= last.x[31:0] * INV_GAIN_Q32;
      p_hi_r   <= last.x[51:32] * INV_GAIN_Q32;
      p_x_r    <= sx;
      p_y_r    <= sy;
      p_ang_r  <= sa;
    end
  end

  assign mprod  = {1'b0, p_hi_r} + {21'b0, p_lo_r[63:32]};
  assign mround = (mprod + 53'd32768) >> 16;

  always_ff @(posedge clk) begin
    if (adv) begin
      o_x_r    <= '0;
      o_y_r    <= '0;
      o_mag_r  <= '0;
      o_ang_r  <= '0;
      o_form_r <= 1'b0;
      o_inv_r  <= 1'b0;
      if (p_form_r == FORM_RECT) begin
        o_x_r <= p_a_r;
        o_y_r <= {{7{p_b_r[24]}}, p_b_r};
        if (!p_zero_r) begin
          o_mag_r <= mround[32:0];
          o_ang_r <= p_ang_r;
        end
      end else if (p_form_r == FORM_POLAR) begin
        o_x_r    <= p_x_r;
        o_y_r    <= p_y_r;
        o_mag_r  <= {p_a_r[31], p_a_r};
        o_ang_r  <= p_b_r;
        o_form_r <= 1'b1;
      end else begin
        o_inv_r <= 1'b1;
      end
    end
  end

  assign out_valid    = o_v_r;
  assign x_coord      = o_x_r;
  assign y_coord      = o_y_r;
  assign magnitude    = o_mag_r;
  assign angle_deg    = o_ang_r;
  assign form_out     = o_form_r;
  assign invalid_form = o_inv_r;

endmodule
`default_nettype wire

// File: design/rpc_checker.sv
// Port-level assertions for the converter, bound to the top level.
`default_nettype none
module rpc_checker (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_tvalid,
  input wire logic         in_tready,
  input wire logic [63:0]  in_tdata,
  input wire logic [1:0]   in_tuser,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [127:0] out_tdata,
  input wire logic [1:0]   out_tuser
);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result shown right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tdata == 128'd0 && !out_tuser[0])
    else $error("invalid request with nonzero result");

  a_rect_mag_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] && !out_tuser[1] |-> !out_tdata[96])
    else $error("negative magnitude for rectangular request");

endmodule

bind rect_polar_converter rpc_checker u_rpc_checker (.*);
`default_nettype wire
